// ===== hdl/circular_deque_macros.svh =====
// ----------------------------------------------------------------------------
// circular_deque assertion macros
// shared property forms for the deque checkers
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication
`define CDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// shared constants, opcodes and control types of the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int VALUE_W       = 32;
	localparam int OP_W          = 3;
	localparam int CAP_W         = 5;

	localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
	localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

	typedef struct packed {
		logic latch;
		logic exec;
		logic rd_en;
	} cmd_t;

endpackage

// ===== hdl/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq_if
// valid/ready channels for deque requests and results
// ----------------------------------------------------------------------------
interface cdq_req_if;
	logic                              valid;
	logic                              ready;
	logic [cdq_pkg::OP_W-1:0]          opcode;
	logic signed [cdq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface cdq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               done_res;
	logic signed [cdq_pkg::VALUE_W-1:0] front_value;
	logic signed [cdq_pkg::VALUE_W-1:0] rear_value;
	logic                               empty_res;
	logic                               full_res;

	modport source (output valid, output done_res, output front_value, output rear_value,
		output empty_res, output full_res, input ready);
	modport sink   (input valid, input done_res, input front_value, input rear_value,
		input empty_res, input full_res, output ready);
endinterface

// ===== hdl/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = cdq_pkg::VALUE_W,
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_a,
	output logic [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== hdl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// sequencer: accept, update, slot read, result beat
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cdq_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_RESP);

	always_comb begin
		cmd.latch = 1'b0;
		cmd.exec  = 1'b0;
		cmd.rd_en = 1'b0;
		state_nx  = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_nx  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = ST_READ;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nx  = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== hdl/cdq_dp.sv =====
// ----------------------------------------------------------------------------
// cdq_dp
// ring pointers, entry count, capacity register and slot memory
// ----------------------------------------------------------------------------
module cdq_dp #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cdq_pkg::cmd_t                      cmd,
	input  logic                               cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0]          cfg_wdata,
	input  logic [cdq_pkg::OP_W-1:0]           req_opcode,
	input  logic signed [cdq_pkg::VALUE_W-1:0] req_value,
	output logic                               done_res,
	output logic signed [cdq_pkg::VALUE_W-1:0] front_value,
	output logic signed [cdq_pkg::VALUE_W-1:0] rear_value,
	output logic                               empty_res,
	output logic                               full_res
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;
	localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(DEPTH);

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	logic [cdq_pkg::CAP_W-1:0]   capacity_q;
	logic [cdq_pkg::OP_W-1:0]    op_q;
	logic [cdq_pkg::VALUE_W-1:0] value_q;
	logic [AW-1:0]               head_q;
	logic [AW-1:0]               tail_q;
	logic [CW-1:0]               count_q;
	logic                        done_q;
	logic                        empty_q;
	logic                        full_q;

	logic [CMPW-1:0]             cap_ext;
	logic [CMPW-1:0]             eff_cap;
	logic                        is_full;
	logic                        is_empty;
	logic [AW-1:0]               head_nx;
	logic [AW-1:0]               tail_nx;
	logic [CW-1:0]               count_nx;
	logic                        done_nx;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [cdq_pkg::VALUE_W-1:0] rdata_a;
	logic [cdq_pkg::VALUE_W-1:0] rdata_b;

	assign cap_ext  = CMPW'(capacity_q);
	assign eff_cap  = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
	assign is_full  = CMPW'(count_q) >= eff_cap;
	assign is_empty = (count_q == '0);

	always_comb begin
		head_nx  = head_q;
		tail_nx  = tail_q;
		count_nx = count_q;
		done_nx  = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		case (op_q)
			cdq_pkg::OP_PUSH_FRONT: begin
				if (!is_full) begin
					head_nx  = ring_prev(head_q);
					wr_en    = 1'b1;
					wr_addr  = ring_prev(head_q);
					count_nx = count_q + CW'(1);
					done_nx  = 1'b1;
				end
			end
			cdq_pkg::OP_PUSH_BACK: begin
				if (!is_full) begin
					tail_nx  = ring_next(tail_q);
					wr_en    = 1'b1;
					count_nx = count_q + CW'(1);
					done_nx  = 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (!is_empty) begin
					head_nx  = ring_next(head_q);
					count_nx = count_q - CW'(1);
					done_nx  = 1'b1;
				end
			end
			cdq_pkg::OP_POP_BACK: begin
				if (!is_empty) begin
					tail_nx  = ring_prev(tail_q);
					count_nx = count_q - CW'(1);
					done_nx  = 1'b1;
				end
			end
			cdq_pkg::OP_QUERY: begin
				done_nx = 1'b1;
			end
			default: begin
				done_nx = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cdq_pkg::CAP_RESET;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				head_q  <= head_nx;
				tail_q  <= tail_nx;
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= req_opcode;
			value_q <= req_value;
		end
		if (cmd.exec) begin
			done_q  <= done_nx;
			empty_q <= (count_nx == '0);
			full_q  <= CMPW'(count_nx) >= eff_cap;
		end
	end

	cdq_ram #(
		.WIDTH (cdq_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (cmd.exec & wr_en),
		.waddr   (wr_addr),
		.wdata   (value_q),
		.re      (cmd.rd_en),
		.raddr_a (head_q),
		.raddr_b (ring_prev(tail_q)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign done_res    = done_q;
	assign empty_res   = empty_q;
	assign full_res    = full_q;
	assign front_value = empty_q ? signed'(cdq_pkg::EMPTY_VALUE) : signed'(rdata_a);
	assign rear_value  = empty_q ? signed'(cdq_pkg::EMPTY_VALUE) : signed'(rdata_b);

endmodule

// ===== hdl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of signed 32-bit entries held in a ring of slots
// ----------------------------------------------------------------------------
// One request beat is handled at a time: the accept state, an update state
// that moves the ring pointers and writes the slot memory, a read state for
// the registered two-port read of the front and rear slots, and the result
// beat, which holds until it is taken; the next request is taken in the cycle
// after that. The capacity register may be written only while no request is
// in flight; values above DEPTH act as DEPTH. No clearing pass runs after
// reset.
module circular_deque #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	cdq_req_if.sink                   req,
	cdq_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [cdq_pkg::CAP_W-1:0] cfg_wdata
);

	cdq_pkg::cmd_t cmd;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	cdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_opcode  (req.opcode),
		.req_value   (req.value),
		.done_res    (rsp.done_res),
		.front_value (rsp.front_value),
		.rear_value  (rsp.rear_value),
		.empty_res   (rsp.empty_res),
		.full_res    (rsp.full_res)
	);

endmodule

// ===== hdl/cdq_chk.sv =====
// ----------------------------------------------------------------------------
// cdq_chk
// port-level checks of the circular deque, bound to the top level
// ----------------------------------------------------------------------------
`include "circular_deque_macros.svh"

module cdq_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic signed [cdq_pkg::VALUE_W-1:0] front_value,
	input  logic signed [cdq_pkg::VALUE_W-1:0] rear_value,
	input  logic                               empty_res
);

	// an empty deque reports all ones at both ends
	`CDQ_ASSERT_SAME(a_empty_ends, clk, arst_n, rsp_valid && empty_res, (front_value == signed'(cdq_pkg::EMPTY_VALUE)) && (rear_value == signed'(cdq_pkg::EMPTY_VALUE)))

	// one beat in flight at a time
	`CDQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)

	// no new request while a result waits
	`CDQ_ASSERT_SAME(a_no_accept_on_rsp, clk, arst_n, rsp_valid, !req_ready)

	// a stalled result beat holds
	`CDQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(front_value) && $stable(rear_value))

endmodule

bind circular_deque cdq_chk u_cdq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.front_value (rsp.front_value),
	.rear_value  (rsp.rear_value),
	.empty_res   (rsp.empty_res)
);

// ===== sim/circular_deque_test.sv =====
// ----------------------------------------------------------------------------
// circular_deque_test
// Regression bench for the circular deque. Request and result beats travel on
// valid/ready channels. Both sides idle at random, and the receiver holds off
// once for a long stretch so that the input side stalls. A behavioural deque
// kept in the bench predicts each result beat, which is then checked field by
// field. Directed items cover the value extremes, every opcode, the undefined
// opcodes, capacity zero and one, and capacity lowered below the live count.
// Random phases follow at several capacities, some above the ring depth, with
// fill, drain and mixed bursts.
// ----------------------------------------------------------------------------
module circular_deque_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = cdq_pkg::DEPTH_DEFAULT;
	localparam int MAX_SHOWN  = 10;

	localparam logic [cdq_pkg::OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
	localparam logic [cdq_pkg::OP_W-1:0] OP_UNDEF_LAST  = 3'd7;

	typedef struct packed {
		logic                        done_res;
		logic [cdq_pkg::VALUE_W-1:0] front_value;
		logic [cdq_pkg::VALUE_W-1:0] rear_value;
		logic                        empty_res;
		logic                        full_res;
	} deque_result_t;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [cdq_pkg::CAP_W-1:0] cfg_wdata;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	circular_deque #(.DEPTH(RING_DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// behavioural deque state
	logic [cdq_pkg::VALUE_W-1:0] ring_slot [RING_DEPTH];
	int unsigned                 ring_head   = 0;
	int unsigned                 ring_tail   = 0;
	int unsigned                 live_count  = 0;
	logic [cdq_pkg::CAP_W-1:0]   cap_setting = cdq_pkg::CAP_RESET;

	deque_result_t expected_results [$];
	int            mismatch_count = 0;
	bit            idle_on        = 1'b0;
	int            hold_order     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("circular_deque regression: fail");
		$finish;
	end

	function automatic deque_result_t predict_deque_result(
		input logic [cdq_pkg::OP_W-1:0] op,
		input logic [cdq_pkg::VALUE_W-1:0] val);
		int unsigned   room;
		bit            was_full;
		bit            was_empty;
		deque_result_t r;
		room      = (cap_setting > RING_DEPTH) ? RING_DEPTH : cap_setting;
		was_full  = live_count >= room;
		was_empty = live_count == 0;
		r.done_res = 1'b0;
		case (op)
			cdq_pkg::OP_PUSH_FRONT: begin
				if (!was_full) begin
					ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
					ring_slot[ring_head] = val;
					live_count++;
					r.done_res = 1'b1;
				end
			end
			cdq_pkg::OP_PUSH_BACK: begin
				if (!was_full) begin
					ring_slot[ring_tail] = val;
					ring_tail = (ring_tail + 1) % RING_DEPTH;
					live_count++;
					r.done_res = 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (!was_empty) begin
					ring_head = (ring_head + 1) % RING_DEPTH;
					live_count--;
					r.done_res = 1'b1;
				end
			end
			cdq_pkg::OP_POP_BACK: begin
				if (!was_empty) begin
					ring_tail = (ring_tail + RING_DEPTH - 1) % RING_DEPTH;
					live_count--;
					r.done_res = 1'b1;
				end
			end
			cdq_pkg::OP_QUERY: begin
				r.done_res = 1'b1;
			end
			default: begin
			end
		endcase
		r.empty_res = live_count == 0;
		r.full_res  = live_count >= room;
		if (r.empty_res) begin
			r.front_value = cdq_pkg::EMPTY_VALUE;
			r.rear_value  = cdq_pkg::EMPTY_VALUE;
		end else begin
			r.front_value = ring_slot[ring_head];
			r.rear_value  = ring_slot[(ring_tail + RING_DEPTH - 1) % RING_DEPTH];
		end
		return r;
	endfunction

	task automatic check_result(input deque_result_t got);
		deque_result_t want;
		if (expected_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_SHOWN) begin
				$display("unexpected result beat: done=%0b front=%0d rear=%0d empty=%0b full=%0b",
					got.done_res, $signed(got.front_value), $signed(got.rear_value),
					got.empty_res, got.full_res);
			end
		end else begin
			want = expected_results.pop_front();
			if (got.done_res !== want.done_res || got.front_value !== want.front_value ||
				got.rear_value !== want.rear_value || got.empty_res !== want.empty_res ||
				got.full_res !== want.full_res) begin
				mismatch_count++;
				if (mismatch_count <= MAX_SHOWN) begin
					$display("result mismatch: expected done=%0b front=%0d rear=%0d empty=%0b full=%0b",
						want.done_res, $signed(want.front_value), $signed(want.rear_value),
						want.empty_res, want.full_res);
					$display("                 actual   done=%0b front=%0d rear=%0d empty=%0b full=%0b",
						got.done_res, $signed(got.front_value), $signed(got.rear_value),
						got.empty_res, got.full_res);
				end
			end
		end
	endtask

	// result side: random stalls per beat, plus a long hold when one is ordered
	initial begin
		int            stall_left;
		int            hold_left;
		deque_result_t seen;
		stall_left = 0;
		hold_left  = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				seen = {rsp_ch.done_res, rsp_ch.front_value, rsp_ch.rear_value,
					rsp_ch.empty_res, rsp_ch.full_res};
				check_result(seen);
				stall_left = idle_on ? $urandom_range(0, 14) : 0;
			end
			if (hold_order > 0) begin
				hold_left  = hold_order;
				hold_order = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_beat(input logic [cdq_pkg::OP_W-1:0] op,
		input logic [cdq_pkg::VALUE_W-1:0] val);
		int            gap;
		deque_result_t want;
		gap = idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.value  <= val;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		want = predict_deque_result(op, val);
		expected_results.insert(expected_results.size(), want);
	endtask

	task automatic settle_deque();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [cdq_pkg::CAP_W-1:0] cap);
		settle_deque();
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we      <= 1'b0;
		cap_setting = cap;
	endtask

	function automatic logic [cdq_pkg::OP_W-1:0] pick_opcode(input traffic_mode_t mode);
		int                       roll;
		int                       push_share;
		logic [cdq_pkg::OP_W-1:0] op;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:  push_share = 70;
			MODE_DRAIN: push_share = 20;
			default:    push_share = 45;
		endcase
		if (roll < 4) begin
			op = cdq_pkg::OP_QUERY;
		end else if (roll < 7) begin
			op = OP_UNDEF_FIRST +
				cdq_pkg::OP_W'($urandom_range(0, OP_UNDEF_LAST - OP_UNDEF_FIRST));
		end else if (roll < 7 + push_share) begin
			op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK;
		end else begin
			op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK;
		end
		return op;
	endfunction

	function automatic logic [cdq_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return cdq_pkg::EMPTY_VALUE;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_basic_ops();
		idle_on = 1'b0;
		send_beat(cdq_pkg::OP_QUERY, '0);
		send_beat(cdq_pkg::OP_POP_FRONT, 32'h1234_5678);
		send_beat(cdq_pkg::OP_POP_BACK, '0);
		send_beat(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
		send_beat(cdq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
		send_beat(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::EMPTY_VALUE);
		send_beat(cdq_pkg::OP_PUSH_BACK, '0);
		for (int k = OP_UNDEF_FIRST; k <= OP_UNDEF_LAST; k++) begin
			send_beat(k[cdq_pkg::OP_W-1:0], $urandom);
		end
		send_beat(cdq_pkg::OP_POP_BACK, '0);
		send_beat(cdq_pkg::OP_POP_FRONT, '0);
		send_beat(cdq_pkg::OP_POP_FRONT, '0);
		send_beat(cdq_pkg::OP_POP_BACK, '0);
		send_beat(cdq_pkg::OP_POP_FRONT, '0);
	endtask

	task automatic test_capacity_corners();
		idle_on = 1'b1;
		// nothing fits at capacity zero
		set_capacity(5'd0);
		send_beat(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
		send_beat(cdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFE);
		set_capacity(5'd1);
		send_beat(cdq_pkg::OP_PUSH_BACK, 32'h5A5A_A5A5);
		send_beat(cdq_pkg::OP_PUSH_FRONT, 32'hA5A5_5A5A);
		send_beat(cdq_pkg::OP_POP_FRONT, '0);
		// shrink below the live count
		set_capacity(5'd16);
		repeat (3) send_beat(cdq_pkg::OP_PUSH_FRONT, $urandom);
		set_capacity(5'd2);
		send_beat(cdq_pkg::OP_PUSH_BACK, $urandom);
		send_beat(cdq_pkg::OP_POP_BACK, '0);
		send_beat(cdq_pkg::OP_POP_FRONT, '0);
	endtask

	task automatic test_backpressure();
		set_capacity(cdq_pkg::CAP_RESET);
		idle_on    = 1'b0;
		hold_order = 80;
		repeat (10) send_beat(cdq_pkg::OP_PUSH_BACK, $urandom);
		settle_deque();
	endtask

	task automatic test_random_traffic();
		logic [cdq_pkg::CAP_W-1:0] phase_cap [10];
		int                        beats;
		traffic_mode_t             mode;
		phase_cap = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd17, 5'd8, 5'd2, 5'd12, 5'd16};
		phase_cap[9] = cdq_pkg::CAP_W'($urandom_range(1, 16));
		mode = MODE_FILL;
		for (int phase = 0; phase < 10; phase++) begin
			idle_on = (phase % 3) != 1;
			set_capacity(phase_cap[phase]);
			beats = (phase_cap[phase] == 0) ? 40 : 190;
			for (int n = 0; n < beats; n++) begin
				if (n % 16 == 0) begin
					mode = traffic_mode_t'($urandom_range(0, 2));
				end
				send_beat(pick_opcode(mode), pick_value());
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.opcode <= cdq_pkg::OP_QUERY;
		req_ch.value  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_capacity_corners();
		test_backpressure();
		test_random_traffic();
		settle_deque();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("circular_deque regression: pass");
		end else begin
			$display("circular_deque regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_if.sv
hdl/cdq_ram.sv
hdl/cdq_ctrl.sv
hdl/cdq_dp.sv
hdl/circular_deque.sv
hdl/cdq_chk.sv
sim/circular_deque_test.sv
